@@ hw/rtl/lphm_pkg.sv @@
package lphm_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_HIT      = 3'd3;
   localparam logic [2:0] ST_MISS     = 3'd4;

   localparam logic CMD_SET = 1'b0;
   localparam logic CMD_GET = 1'b1;

   localparam logic [9:0] MAX_ENTRIES_RESET = 10'd768;

   typedef struct packed {
      logic        cmd;
      logic [63:0] key_bytes;
      logic [63:0] new_value;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] read_value;
   } rsp_type;

   // hashed item passed from front to back
   typedef struct packed {
      logic        cmd;
      logic [63:0] key;
      logic [63:0] hash;
      logic [63:0] value;
   } job_type;

endpackage

@@ hw/rtl/lphm_ram.sv @@
module lphm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/lphm_front.sv @@
module lphm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lphm_pkg::req_type req_data,
   output logic              job_valid,
   input  logic              job_stall,
   output lphm_pkg::job_type job_data
);
   import lphm_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_HASH = 2'd1;
   localparam logic [1:0] S_MUL  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  byte_ff, byte_in;
   logic [63:0] key_ff, key_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] value_ff, value_in;
   logic        cmd_ff, cmd_in;
   logic [63:0] canon;
   logic        stop;
   logic [7:0]  cur_byte;

   // key canonical form, bytes after first zero cleared
   always_comb begin
      logic dead;
      dead  = 1'b0;
      canon = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_data.key_bytes[8*i +: 8] == 8'd0) dead = 1'b1;
         if (!dead) canon[8*i +: 8] = req_data.key_bytes[8*i +: 8];
      end
   end

   assign cur_byte = key_ff[8*byte_ff +: 8];
   assign stop     = (cur_byte == 8'd0);

   assign req_stall = (state_ff != S_IDLE);
   assign job_valid = (state_ff == S_OUT);
   assign job_data  = '{cmd: cmd_ff, key: key_ff, hash: hash_ff, value: value_ff};

   // each fnv round is an xor state, then a multiply state
   always_comb begin
      state_in = state_ff;
      byte_in  = byte_ff;
      key_in   = key_ff;
      hash_in  = hash_ff;
      value_in = value_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = canon;
               value_in = req_data.new_value;
               cmd_in   = req_data.cmd;
               hash_in  = FNV_BASIS;
               byte_in  = 3'd0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            if (stop) begin
               state_in = S_OUT;
            end else begin
               hash_in  = hash_ff ^ {56'd0, cur_byte};
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // prime is 2**40 + 0x1b3, so the product is a sum of shifts
            hash_in = (hash_ff << 40) + (hash_ff << 8) + (hash_ff << 7) +
                      (hash_ff << 5) + (hash_ff << 4) + (hash_ff << 1) + hash_ff;
            byte_in = byte_ff + 3'd1;
            state_in = (byte_ff == 3'd7) ? S_OUT : S_HASH;
         end
         S_OUT: begin
            if (!job_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      byte_ff  <= byte_in;
      key_ff   <= key_in;
      hash_ff  <= hash_in;
      value_ff <= value_in;
      cmd_ff   <= cmd_in;
   end
endmodule

@@ hw/rtl/lphm_queue.sv @@
module lphm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  lphm_pkg::job_type in_data,
   output logic              out_valid,
   input  logic              out_take,
   output lphm_pkg::job_type out_data
);
   import lphm_pkg::*;

   job_type    ent_ff [2];
   logic [1:0] count_ff;
   logic       rd_ff, wr_ff;
   logic       push, pop;

   assign in_stall  = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = ent_ff[rd_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && out_take;

   // two-entry queue between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
      end
      if (push) ent_ff[wr_ff] <= in_data;
   end
endmodule

@@ hw/rtl/lphm_back.sv @@
module lphm_back #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [9:0]        max_entries,
   input  logic              job_valid,
   output logic              job_take,
   input  lphm_pkg::job_type job_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lphm_pkg::rsp_type rsp_data
);
   import lphm_pkg::*;

   localparam int AW = $clog2(TABLE_SLOTS);
   localparam int CW = AW + 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(TABLE_SLOTS);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic [10:0]   count_ff, count_in;
   job_type       job_ff, job_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_used, used_wdata, wr_kv;
   logic [AW-1:0] wr_addr;
   logic          used_q;
   logic [63:0]   key_q, val_q;
   logic [63:0]   val_wdata;

   lphm_ram #(.WIDTH(1), .DEPTH(TABLE_SLOTS)) u_used (
      .clock, .wr_en(wr_used), .wr_addr, .wr_data(used_wdata),
      .rd_addr(idx_ff), .rd_data(used_q));
   lphm_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_key (
      .clock, .wr_en(wr_kv && job_ff.cmd == CMD_SET && !used_q), .wr_addr,
      .wr_data(job_ff.key), .rd_addr(idx_ff), .rd_data(key_q));
   lphm_ram #(.WIDTH(64), .DEPTH(TABLE_SLOTS)) u_val (
      .clock, .wr_en(wr_kv), .wr_addr, .wr_data(val_wdata),
      .rd_addr(idx_ff), .rd_data(val_q));

   assign val_wdata = job_ff.value;
   assign job_take  = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   // probe sequencer; clear sweep after reset
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      seen_in    = seen_ff;
      count_in   = count_ff;
      job_in     = job_ff;
      rsp_in     = rsp_ff;
      wr_used    = 1'b0;
      used_wdata = 1'b0;
      wr_kv      = 1'b0;
      wr_addr    = idx_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_used = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == AW'(TABLE_SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (job_valid) begin
               job_in   = job_data;
               idx_in   = job_data.hash[AW-1:0];
               seen_in  = '0;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_WAIT;
         S_WAIT: state_in = S_CHECK;
         S_CHECK: begin
            state_in = S_OUT;
            rsp_in.read_value = '0;
            if (!used_q) begin
               if (job_ff.cmd == CMD_GET) begin
                  rsp_in.status = ST_MISS;
               end else if ({1'b0, count_ff} + 12'd1 > {2'b0, max_entries}) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  wr_used    = 1'b1;
                  used_wdata = 1'b1;
                  wr_kv      = 1'b1;
                  count_in   = count_ff + 11'd1;
                  rsp_in.status = ST_INSERTED;
               end
            end else if (key_q == job_ff.key) begin
               if (job_ff.cmd == CMD_GET) begin
                  rsp_in.status     = ST_HIT;
                  rsp_in.read_value = val_q;
               end else begin
                  wr_kv         = 1'b1;
                  rsp_in.status = ST_UPDATED;
               end
            end else if (seen_ff + 1'b1 == SLOTS_C) begin
               rsp_in.status = (job_ff.cmd == CMD_GET) ? ST_MISS : ST_FULL;
            end else begin
               seen_in  = seen_ff + 1'b1;
               idx_in   = idx_ff + 1'b1;
               state_in = S_WAIT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
      seen_ff <= seen_in;
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
   end
endmodule

@@ hw/rtl/linear_probe_hash_map_core.sv @@
// Open-addressing key-value table, FNV-1a 64 hash, linear probing. A hashing
// front end handles each key byte in an xor step, then a shift-and-add multiply
// by the prime, and hands items through a two-entry queue to a probe
// sequencer, which reads slots from its registered-read RAMs. Front and back
// can work on different items at once. After reset the back end sweeps the
// used-bit RAM before it starts work; csr writes are taken at any time.
module linear_probe_hash_map_core #(
   parameter int TABLE_SLOTS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lphm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lphm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [9:0]        csr_data
);
   import lphm_pkg::*;

   logic       fj_valid, fj_stall, bj_valid, bj_take;
   job_type    fj_data, bj_data;
   logic [9:0] max_entries_ff;

   assign csr_ready = 1'b1;

   // entry limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= MAX_ENTRIES_RESET;
      end else if (csr_valid && csr_ready) begin
         max_entries_ff <= csr_data;
      end
   end

   lphm_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .job_valid(fj_valid), .job_stall(fj_stall), .job_data(fj_data));

   lphm_queue u_queue (
      .clock, .reset, .in_valid(fj_valid), .in_stall(fj_stall), .in_data(fj_data),
      .out_valid(bj_valid), .out_take(bj_take), .out_data(bj_data));

   lphm_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
      .clock, .reset, .max_entries(max_entries_ff),
      .job_valid(bj_valid), .job_take(bj_take), .job_data(bj_data),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

@@ hw/rtl/lphm_checker.sv @@
module lphm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input lphm_pkg::rsp_type rsp_data
);
   import lphm_pkg::*;

   // status code is in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_MISS)
      else $error("status out of range");

   // read value is zero unless get hit
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_HIT |-> rsp_data.read_value == 64'd0)
      else $error("nonzero read value");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped");

   // an accepted item makes the input stall next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after item");

   // no result right out of reset
   a_reset: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind linear_probe_hash_map_core lphm_checker u_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_data);
